FILE: design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// a implies c in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

// a never holds
`define ASSERT_NEVER(label, clk, rst_n, a) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("forbidden condition seen");

`endif

FILE: design/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

  localparam int WORD_W  = 64;
  localparam int CHUNK_W = 8;
  localparam int CI_W    = 3;

  localparam int KIND_W  = 1;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 2;
  localparam int FREE_W  = 13;
  localparam int LIMIT_W = 13;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [0:0]         REG_SEARCH_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 13'd4096;

  typedef enum logic [KIND_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 2'd0,
    STS_BAD_COUNT = 2'd1,
    STS_NO_RUN    = 2'd2
  } status_t;

endpackage

FILE: design/bpa_in_if.sv
// Request channel of the page allocator: valid/ready plus request word.
// Depends on bpa_pkg.
interface bpa_in_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  page_index;
  logic [CNT_W-1:0]  run_pages;

  modport source (output valid, kind, page_index, run_pages, input ready);
  modport sink   (input valid, kind, page_index, run_pages, output ready);
endinterface

FILE: design/bpa_out_if.sv
// Result channel of the page allocator: valid/ready plus result word.
// Depends on bpa_pkg.
interface bpa_out_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  start_page;
  logic [FREE_W-1:0] free_pages;

  modport source (output valid, status, start_page, free_pages, input ready);
  modport sink   (input valid, status, start_page, free_pages, output ready);
endinterface

FILE: design/bpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bpa_cfg.sv
// APB-style register file of the allocator: search limit register.
// Depends on bpa_pkg.
module bpa_cfg import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  output logic [LIMIT_W-1:0] search_limit
);

  logic [LIMIT_W-1:0] limit_r;
  logic               wr_en;
  logic [0:0]         reg_idx;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (wr_en && (reg_idx == REG_SEARCH_LIMIT)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SEARCH_LIMIT) begin
      prdata = CFG_DW'(limit_r);
    end
  end

  assign search_limit = limit_r;

endmodule

FILE: design/bitmap_page_allocator_unit.sv
// Flow, accept to result handshake: a bad count goes straight to the result; a free
// reads and rewrites each 64-page map word it touches; an allocate scans map words
// (one RAM read, eight 8-page steps each) and marks a found run word by word; a search
// limit on a word boundary ends the scan at the next word read. One request at a time,
// input ready only while idle. Reset: map RAM filled with all-used, word by word, input
// not ready meanwhile; usable counter cleared, search limit 4096.
module bitmap_page_allocator_unit import bpa_pkg::*; #(
  parameter int NUM_PAGES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  bpa_in_if.sink            in_ch,
  bpa_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

`include "assert_macros.svh"

  localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RW    = (AW + 7 > 15) ? AW + 7 : 15;
  localparam int CW    = $clog2(NUM_PAGES + 1);
  localparam logic [RW-1:0] NP     = RW'(NUM_PAGES);
  localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_MARK_RD, ST_MARK_WR, ST_FIN
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      w_r;
  logic [CI_W-1:0]    c_r;
  logic [CNT_W-1:0]   run_r;
  logic [CNT_W-1:0]   count_r;
  logic [RW-1:0]      limit_r;
  logic [RW-1:0]      lo_r;
  logic [RW-1:0]      last_r;
  logic               set_r;
  logic [CW-1:0]      usable_r;
  status_t            res_status_r;
  logic [IDX_W-1:0]   res_start_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [IDX_W-1:0]   out_start_r;
  logic [FREE_W-1:0]  out_free_r;

  logic [LIMIT_W-1:0] search_limit;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  bpa_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .search_limit (search_limit)
  );

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  logic          in_acc;
  logic          bad_cnt;
  logic [RW-1:0] cnt_ext;
  logic [RW-1:0] first_ext;
  logic [RW-1:0] end_ext;
  logic [RW-1:0] free_hi;
  logic [RW-1:0] free_done;
  logic [RW-1:0] free_sum;
  logic [RW-1:0] lim_ext;
  logic [RW-1:0] lim_eff;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cnt_ext     = RW'(in_ch.run_pages);
  assign first_ext   = RW'(in_ch.page_index);
  assign bad_cnt     = (in_ch.run_pages == '0) || (cnt_ext > NP);
  assign end_ext     = first_ext + cnt_ext;
  assign free_hi     = (end_ext > NP) ? NP : end_ext;
  assign free_done   = (first_ext >= NP) ? '0 : free_hi - first_ext;
  assign free_sum    = RW'(usable_r) + free_done;
  assign lim_ext     = RW'(search_limit);
  assign lim_eff     = (lim_ext > NP) ? NP : lim_ext;

  // 8-page scan step over the current map word
  logic [CHUNK_W-1:0] chunk_bits;
  logic [CNT_W-1:0]   run_v;
  logic               hit;
  logic [RW-1:0]      hit_page;
  logic [RW-1:0]      page_j;
  logic               used_j;
  logic [RW-1:0]      alloc_lo;
  logic [RW-1:0]      alloc_left;

  assign chunk_bits = ram_rdata[{c_r, 3'd0} +: CHUNK_W];

  always_comb begin
    run_v    = run_r;
    hit      = 1'b0;
    hit_page = '0;
    page_j   = '0;
    used_j   = 1'b0;
    for (int j = 0; j < CHUNK_W; j++) begin
      page_j = RW'({w_r, c_r, 3'(j)});
      used_j = chunk_bits[j] || (page_j >= limit_r);
      run_v  = used_j ? '0 : run_v + 1'b1;
      if (!hit && !used_j && (run_v == count_r)) begin
        hit      = 1'b1;
        hit_page = page_j;
      end
    end
  end

  assign alloc_lo   = hit_page + RW'(1) - RW'(count_r);
  assign alloc_left = (RW'(usable_r) > RW'(count_r)) ? RW'(usable_r) - RW'(count_r) : '0;

  // read-modify-write mask for the word under w_r
  logic [AW-1:0]     lo_w;
  logic [AW-1:0]     last_w;
  logic [5:0]        lo_off;
  logic [5:0]        hi_off;
  logic [WORD_W-1:0] mask;

  assign lo_w   = lo_r[AW+5:6];
  assign last_w = last_r[AW+5:6];
  assign lo_off = (w_r == lo_w) ? lo_r[5:0] : 6'd0;
  assign hi_off = (w_r == last_w) ? last_r[5:0] : 6'd63;
  assign mask   = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (6'd63 - hi_off));

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = w_r;
    ram_raddr = w_r;
    ram_wdata = {WORD_W{1'b1}};
    unique case (state_r)
      ST_INIT: begin
        ram_we = 1'b1;
      end
      ST_SCAN_RD: begin
        ram_re = (RW'({w_r, 6'd0}) < limit_r);
      end
      ST_MARK_RD: begin
        ram_re = 1'b1;
      end
      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      w_r         <= '0;
      usable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // ST_FIN either holds the word or reloads it
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          if (w_r == LAST_W) begin
            state_r <= ST_IDLE;
          end else begin
            w_r <= w_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_start_r <= '0;
            if (bad_cnt) begin
              res_status_r <= STS_BAD_COUNT;
              state_r      <= ST_FIN;
            end else if (in_ch.kind == OP_FREE) begin
              res_status_r <= STS_OK;
              usable_r     <= CW'((free_sum > NP) ? NP : free_sum);
              lo_r         <= first_ext;
              last_r       <= free_hi - RW'(1);
              set_r        <= 1'b0;
              w_r          <= first_ext[AW+5:6];
              state_r      <= (free_done == '0) ? ST_FIN : ST_MARK_RD;
            end else begin
              count_r <= in_ch.run_pages;
              limit_r <= lim_eff;
              run_r   <= '0;
              w_r     <= '0;
              state_r <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          c_r <= '0;
          if (RW'({w_r, 6'd0}) >= limit_r) begin
            res_status_r <= STS_NO_RUN;
            state_r      <= ST_FIN;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_status_r <= STS_OK;
            res_start_r  <= IDX_W'(alloc_lo);
            usable_r     <= CW'(alloc_left);
            lo_r         <= alloc_lo;
            last_r       <= hit_page;
            set_r        <= 1'b1;
            w_r          <= alloc_lo[AW+5:6];
            state_r      <= ST_MARK_RD;
          end else begin
            run_r <= run_v;
            c_r   <= c_r + 1'b1;
            if (c_r == {CI_W{1'b1}}) begin
              if (w_r == LAST_W) begin
                res_status_r <= STS_NO_RUN;
                state_r      <= ST_FIN;
              end else begin
                w_r     <= w_r + 1'b1;
                state_r <= ST_SCAN_RD;
              end
            end
          end
        end
        ST_MARK_RD: begin
          state_r <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          if (w_r == last_w) begin
            state_r <= ST_FIN;
          end else begin
            w_r     <= w_r + 1'b1;
            state_r <= ST_MARK_RD;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_start_r  <= res_start_r;
            out_free_r   <= FREE_W'(usable_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.start_page = out_start_r;
  assign out_ch.free_pages = out_free_r;

  `ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, ram_we && ram_re)
  `ASSERT_NEVER(a_count_bound, clk, rst_n, RW'(usable_r) > NP)
  `ASSERT_NEXT(a_bad_to_fin, clk, rst_n, in_acc && bad_cnt, state_r == ST_FIN)
  `ASSERT_IMPLIES(a_mark_in_range, clk, rst_n, state_r == ST_MARK_WR, (w_r >= lo_w) && (w_r <= last_w))

endmodule
